// ===== src/ihex_pkg.sv =====
// shared types, constants and helpers of the hex record decoder
package ihex_pkg;

  // character codes
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  // record type of the end-of-file record
  localparam logic [7:0] RecTypeEof = 8'h01;

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // kind of a decoded word passed from front to back
  typedef enum logic [1:0] {
    KIND_ADDR_HI = 2'd0,
    KIND_ADDR_LO = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_END     = 2'd3
  } word_kind_e;

  // one decoded word
  typedef struct packed {
    word_kind_e kind;
    logic [7:0] value;
  } word_t;

  // value of one hex digit, zero for anything else
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c >= CharUpA && c <= CharUpF) begin
      diff = c - CharUpA + 8'd10;
    end else if (c >= CharZero && c <= CharNine) begin
      diff = c - CharZero;
    end
    return diff[3:0];
  endfunction

endpackage

// ===== src/ihex_front.sv =====
// character front end: hunts for records, pairs digits, classifies bytes
module ihex_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_char_i,
  output logic              wr_en_o,
  output ihex_pkg::word_t   wr_word_o
);

  typedef enum logic [6:0] {
    PH_HUNT = 7'b0000001,
    PH_LEN  = 7'b0000010,
    PH_AHI  = 7'b0000100,
    PH_ALO  = 7'b0001000,
    PH_TYPE = 7'b0010000,
    PH_DATA = 7'b0100000,
    PH_CSUM = 7'b1000000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       second_q, second_d;
  logic [3:0] high_q, high_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic       finished_q, finished_d;
  logic [3:0] digit;
  logic [7:0] byte_val;

  assign digit    = ihex_pkg::digit_value(text_char_i);
  assign byte_val = {high_q, digit};

  // record parse state machine
  always_comb begin
    phase_d    = phase_q;
    second_d   = second_q;
    high_d     = high_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    finished_d = finished_q;
    wr_en_o    = 1'b0;
    wr_word_o  = '{kind: ihex_pkg::KIND_DATA, value: byte_val};
    if (accept_i && !finished_q) begin
      if (phase_q == PH_HUNT) begin
        if (text_char_i == ihex_pkg::CharColon) begin
          phase_d  = PH_LEN;
          second_d = 1'b0;
        end
      end else if (!second_q) begin
        high_d   = digit;
        second_d = 1'b1;
      end else begin
        second_d = 1'b0;
        unique case (phase_q)
          PH_LEN: begin
            len_d   = byte_val;
            phase_d = PH_AHI;
          end
          PH_AHI: begin
            wr_en_o        = 1'b1;
            wr_word_o.kind = ihex_pkg::KIND_ADDR_HI;
            phase_d        = PH_ALO;
          end
          PH_ALO: begin
            wr_en_o        = 1'b1;
            wr_word_o.kind = ihex_pkg::KIND_ADDR_LO;
            phase_d        = PH_TYPE;
          end
          PH_TYPE: begin
            if (byte_val == ihex_pkg::RecTypeEof) begin
              wr_en_o        = 1'b1;
              wr_word_o.kind = ihex_pkg::KIND_END;
              finished_d     = 1'b1;
            end else begin
              cnt_d   = 8'd0;
              phase_d = (len_q == 8'd0) ? PH_CSUM : PH_DATA;
            end
          end
          PH_DATA: begin
            wr_en_o = 1'b1;
            cnt_d   = cnt_q + 8'd1;
            if (cnt_d == len_q) begin
              phase_d = PH_CSUM;
            end
          end
          PH_CSUM: begin
            phase_d = PH_HUNT;
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      second_q   <= 1'b0;
      high_q     <= 4'd0;
      len_q      <= 8'd0;
      cnt_q      <= 8'd0;
      finished_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      second_q   <= second_d;
      high_q     <= high_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      finished_q <= finished_d;
    end
  end

endmodule

// ===== src/ihex_fifo.sv =====
// short queue of decoded words between front and back
module ihex_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  ihex_pkg::word_t wr_word_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output logic            rd_valid_o,
  output ihex_pkg::word_t rd_word_o
);

  ihex_pkg::word_t                   mem_q [ihex_pkg::QueueDepth];
  logic [ihex_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [ihex_pkg::QueueCntW-1:0]    count_q;
  logic                              do_wr, do_rd;

  assign full_o     = (count_q == ihex_pkg::QueueCntW'(ihex_pkg::QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_word_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_word_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/ihex_back.sv =====
// back end: tracks the record address and builds result words
module ihex_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  ihex_pkg::word_t in_word_i,
  output logic            in_take_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [15:0]     write_address_o,
  output logic [7:0]      write_data_o,
  output logic            end_of_file_o
);

  logic [15:0] addr_q, addr_d;
  logic [7:0]  index_q, index_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_addr_q, out_addr_d;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_eof_q, out_eof_d;
  logic        produce;

  assign in_take_o = in_valid_i && (!out_valid_q || pop_i);

  // word execution
  always_comb begin
    addr_d     = addr_q;
    index_d    = index_q;
    out_addr_d = out_addr_q;
    out_data_d = out_data_q;
    out_eof_d  = out_eof_q;
    produce    = 1'b0;
    if (in_take_o) begin
      unique case (in_word_i.kind)
        ihex_pkg::KIND_ADDR_HI: begin
          addr_d = {in_word_i.value, addr_q[7:0]};
        end
        ihex_pkg::KIND_ADDR_LO: begin
          addr_d  = {addr_q[15:8], in_word_i.value};
          index_d = 8'd0;
        end
        ihex_pkg::KIND_DATA: begin
          produce    = 1'b1;
          out_addr_d = addr_q + {8'd0, index_q};
          out_data_d = in_word_i.value;
          out_eof_d  = 1'b0;
          index_d    = index_q + 8'd1;
        end
        ihex_pkg::KIND_END: begin
          produce    = 1'b1;
          out_addr_d = 16'd0;
          out_data_d = 8'd0;
          out_eof_d  = 1'b1;
        end
        default: begin
          produce = 1'b0;
        end
      endcase
    end
  end

  // output register valid
  always_comb begin
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= 16'd0;
      index_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      addr_q      <= addr_d;
      index_q     <= index_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_addr_q <= out_addr_d;
    out_data_q <= out_data_d;
    out_eof_q  <= out_eof_d;
  end

  assign empty_o         = !out_valid_q;
  assign write_address_o = out_addr_q;
  assign write_data_o    = out_data_q;
  assign end_of_file_o   = out_eof_q;

endmodule

// ===== src/intel_hex_record_decoder.sv =====
// top level of the hex record decoder
//
//   channel   direction  ports                                         handshake
//   text      in         text_char_i                                   push_i / full_o
//   result    out        write_address_o, write_data_o, end_of_file_o  pop_i / empty_o
//
// one character is taken per cycle while full_o is low; the front parser
// handles each as it is taken. the character that completes a byte writes it
// into the queue, from which the back end loads its output register.
// full_o rises only when the four-word queue fills because pops stall.
// after reset the parser hunts for a colon; after an end-of-file record
// all characters are taken and dropped until the next reset.
module intel_hex_record_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  text_char_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic        end_of_file_o
);

  logic            accept;
  logic            wr_en;
  ihex_pkg::word_t wr_word;
  logic            rd_valid;
  logic            rd_take;
  ihex_pkg::word_t rd_word;

  assign accept = push_i && !full_o;

  // character parser
  ihex_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_char_i (text_char_i),
    .wr_en_o     (wr_en),
    .wr_word_o   (wr_word)
  );

  // decoupling queue
  ihex_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_word_i  (wr_word),
    .full_o     (full_o),
    .rd_en_i    (rd_take),
    .rd_valid_o (rd_valid),
    .rd_word_o  (rd_word)
  );

  // address tracking and result register
  ihex_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (rd_valid),
    .in_word_i       (rd_word),
    .in_take_o       (rd_take),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .end_of_file_o   (end_of_file_o)
  );

  // end mark carries a zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && end_of_file_o) |-> (write_address_o == 16'd0 && write_data_o == 8'd0))
    else $error("end mark with nonzero payload");

  // nothing follows the end mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && end_of_file_o) |=> empty_o)
    else $error("result after end mark");

  // queue fills only through an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i && !full_o))
    else $error("queue filled without a push");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the intel hex record decoder
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned DrainCycles = 20;

  // parser phases as the decoder walks through a record
  typedef enum logic [2:0] {
    PHASE_HUNT     = 3'd0,
    PHASE_LENGTH   = 3'd1,
    PHASE_ADDR_HI  = 3'd2,
    PHASE_ADDR_LO  = 3'd3,
    PHASE_TYPE     = 3'd4,
    PHASE_DATA     = 3'd5,
    PHASE_CHECKSUM = 3'd6
  } parse_phase_e;

  // one image write as it should leave the decoder
  typedef struct {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        eof;
  } image_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [7:0]  text_char_i = 8'h00;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [15:0] write_address_o;
  logic [7:0]  write_data_o;
  logic        end_of_file_o;

  // decoder state as predicted from the accepted characters
  parse_phase_e phase = PHASE_HUNT;
  logic         low_nibble_due = 1'b0;
  logic [3:0]   first_nibble = 4'h0;
  logic [7:0]   rec_len = 8'h00;
  logic [15:0]  rec_addr = 16'h0000;
  logic [7:0]   byte_idx = 8'h00;
  logic         eof_seen = 1'b0;

  image_write_t pending_writes[$];

  // run bookkeeping
  int unsigned chars_sent = 0;
  int unsigned writes_seen = 0;
  int unsigned eof_marks_seen = 0;
  int unsigned fail_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned sloppy_pct = 0;
  bit          calm_push = 1'b0;
  bit          calm_pop = 1'b0;
  bit          eof_allowed = 1'b0;

  intel_hex_record_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .text_char_i    (text_char_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .end_of_file_o  (end_of_file_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // value of a hex digit, anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c inside {[ihex_pkg::CharZero : ihex_pkg::CharNine]}) return c[3:0];
    if (c inside {[ihex_pkg::CharUpA : ihex_pkg::CharUpF]}) return c[3:0] + 4'd9;
    return 4'h0;
  endfunction

  // advance the predicted parser by one character, queue any image write
  function void decode_char(input logic [7:0] c);
    logic [7:0]   pair;
    logic [15:0]  target;
    image_write_t w;
    if (eof_seen) return;
    if (phase == PHASE_HUNT) begin
      if (c == ihex_pkg::CharColon) begin
        phase = PHASE_LENGTH;
        low_nibble_due = 1'b0;
      end
      return;
    end
    if (!low_nibble_due) begin
      first_nibble = hex_value(c);
      low_nibble_due = 1'b1;
      return;
    end
    low_nibble_due = 1'b0;
    pair = {first_nibble, hex_value(c)};
    case (phase)
      PHASE_LENGTH: begin
        rec_len = pair;
        phase = PHASE_ADDR_HI;
      end
      PHASE_ADDR_HI: begin
        rec_addr = {pair, 8'h00};
        phase = PHASE_ADDR_LO;
      end
      PHASE_ADDR_LO: begin
        rec_addr[7:0] = pair;
        phase = PHASE_TYPE;
      end
      PHASE_TYPE: begin
        if (pair == ihex_pkg::RecTypeEof) begin
          eof_seen = 1'b1;
          w.addr = 16'h0000;
          w.data = 8'h00;
          w.eof = 1'b1;
          pending_writes.push_back(w);
        end else begin
          byte_idx = 8'h00;
          if (rec_len == 8'h00) phase = PHASE_CHECKSUM;
          else phase = PHASE_DATA;
        end
      end
      PHASE_DATA: begin
        target = rec_addr + {8'h00, byte_idx};
        w.addr = target;
        w.data = pair;
        w.eof = 1'b0;
        pending_writes.push_back(w);
        byte_idx = byte_idx + 8'd1;
        if (byte_idx == rec_len) phase = PHASE_CHECKSUM;
      end
      default: begin
        // checksum digits are dropped unchecked
        phase = PHASE_HUNT;
      end
    endcase
  endfunction

  // random idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one character word and wait until it is taken
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = idle_len(calm_push);
    // keep the end mark for the last test only
    if (!eof_allowed && phase == PHASE_TYPE && low_nibble_due &&
        {first_nibble, hex_value(c)} == ihex_pkg::RecTypeEof) begin
      c = "2";
    end
    if (gap != 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    text_char_i <= c;
    do @(posedge clk_i); while (full_o);
    decode_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // two hex digits, now and then a random character in place of a digit
  task automatic send_hex_byte(input logic [7:0] b);
    logic [3:0] nib;
    logic [7:0] c;
    for (int i = 1; i >= 0; i--) begin
      nib = (i == 1) ? b[7:4] : b[3:0];
      if ($urandom_range(0, 99) < sloppy_pct) c = 8'($urandom_range(0, 255));
      else if (nib < 4'd10) c = ihex_pkg::CharZero + {4'h0, nib};
      else c = ihex_pkg::CharUpA + {4'h0, nib} - 8'd10;
      send_char(c);
    end
  endtask

  // stop sending until every queued write has come out
  task automatic wait_drained();
    push_i <= 1'b0;
    do @(posedge clk_i); while (pending_writes.size() != 0);
  endtask

  // result side: check each popped word, then pick the next pop
  always @(posedge clk_i) begin : result_side
    image_write_t w;
    int unsigned r;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_writes.size() == 0) begin
        $display("%0t ns: unexpected word addr %h data %h eof %b", $time,
                 write_address_o, write_data_o, end_of_file_o);
        fail_count++;
      end else begin
        w = pending_writes.pop_front();
        if (write_address_o !== w.addr) begin
          $display("%0t ns: write_address expected %h got %h", $time, w.addr, write_address_o);
          fail_count++;
        end
        if (write_data_o !== w.data) begin
          $display("%0t ns: write_data expected %h got %h", $time, w.data, write_data_o);
          fail_count++;
        end
        if (end_of_file_o !== w.eof) begin
          $display("%0t ns: end_of_file expected %b got %b", $time, w.eof, end_of_file_o);
          fail_count++;
        end
        if (w.eof) eof_marks_seen++;
        else writes_seen++;
      end
    end
    // pop stalls: mostly short, a few long
    r = $urandom_range(0, 99);
    if (calm_pop) begin
      pop_i <= 1'b1;
    end else if (stall_left != 0) begin
      pop_i <= 1'b0;
      stall_left--;
    end else if (r < 60) begin
      pop_i <= 1'b1;
    end else begin
      pop_i <= 1'b0;
      stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t ns: no word moved for %0d cycles", $time, StuckLimit);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // leading junk, max data, wrap at ffff, lowercase and colon as digits,
  // an odd record type and a zero-length record
  task automatic test_directed_records();
    send_text("Z:02FFFF00FFa:CC");
    send_text(":0012349F77");
  endtask

  // mostly well-formed records with random content, plus junk and cut records
  task automatic test_random_records(input int unsigned target);
    int unsigned kind, len, r, stop_at;
    logic [15:0] addr;
    logic [7:0]  rtype, b;
    while (chars_sent < target) begin
      calm_push = ($urandom_range(0, 9) == 0);
      calm_pop = ($urandom_range(0, 9) == 0);
      sloppy_pct = ($urandom_range(0, 3) == 0) ? 8 : 0;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3 && chars_sent + 600 < target) len = (r == 0) ? 255 : $urandom_range(128, 254);
        else if (r < 15) len = $urandom_range(7, 32);
        else len = $urandom_range(0, 6);
        addr = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 7))
                                           : 16'($urandom);
        rtype = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(2, 255));
        stop_at = (kind < 22) ? $urandom_range(0, len + 4) : len + 5;
        send_char(ihex_pkg::CharColon);
        for (int k = 0; k < stop_at; k++) begin
          if (k == 0) b = 8'(len);
          else if (k == 1) b = addr[15:8];
          else if (k == 2) b = addr[7:0];
          else if (k == 3) b = rtype;
          else if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          else b = 8'($urandom);
          send_hex_byte(b);
        end
        if ($urandom_range(0, 1) == 1) send_text("\r\n");
      end
    end
    calm_push = 1'b0;
    calm_pop = 1'b0;
    sloppy_pct = 0;
  endtask

  // sender holds off until the result side is empty
  task automatic test_drain_pause();
    wait_drained();
  endtask

  // end-of-file record, then everything after it must be dropped
  task automatic test_end_of_file();
    while (phase != PHASE_HUNT) send_char(ihex_pkg::CharZero);
    eof_allowed = 1'b1;
    send_text(":00000001FF");
    send_text("\r\n:0210000055AA00\r\n:00000001FF");
    repeat (8) send_char(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_records();
    test_random_records(700);
    test_drain_pause();
    test_random_records(1500);
    test_end_of_file();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d characters: %0d data writes and %0d end marks checked",
             chars_sent, writes_seen, eof_marks_seen);
    $display("records of random length, address and type with junk, cut records and stalls");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== intel_hex_record_decoder.f =====
src/ihex_pkg.sv
src/ihex_front.sv
src/ihex_fifo.sv
src/ihex_back.sv
src/intel_hex_record_decoder.sv
tb/sv/tb_top.sv
